// ===== design/swa_pkg.sv =====
package swa_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned Rows    = 5;
  localparam int unsigned Cols    = 5;
  localparam int unsigned Held    = 4;
  localparam int unsigned CapW    = 11;
  localparam int unsigned DiffW   = 19;
  localparam int unsigned AbsW    = 18;
  localparam int unsigned ColSumW = 15;
  localparam int unsigned TotalW  = 19;

  localparam logic [CapW-1:0]   CapMask   = 11'h7f8;
  localparam logic [TotalW-1:0] RoundBias = 19'h40;
  localparam logic [7:0]        OutMax    = 8'hff;

  localparam logic [2:0] ColWeight [Cols] = '{3'd1, 3'd4, 3'd6, 3'd4, 3'd1};

  typedef logic signed [SampleW-1:0] sample_t;
  typedef sample_t [Rows-1:0]        column_t;
  typedef column_t [Cols-1:0]        window_t;

  typedef logic [CapW-1:0]  term_t;
  typedef term_t [2:0]      col_terms_t;
  typedef col_terms_t [Cols-1:0] terms_t;

  typedef struct packed {
    logic    fire;
    window_t win;
  } window_out_t;

endpackage

// ===== design/swa_window.sv =====
module swa_window
  import swa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  column_t     column_i,
  input  logic        line_start_i,
  output window_out_t win_o
);

  column_t    store_q [Held];
  logic [2:0] fill_q, fill_d;
  logic [2:0] held;

  assign held = line_start_i ? 3'd0 : fill_q;
  assign fill_d = (held < 3'(Held)) ? held + 3'd1 : 3'(Held);

  always_comb begin
    win_o.fire = (held >= 3'(Held));
    for (int c = 0; c < Held; c++) begin
      win_o.win[c] = store_q[c];
    end
    win_o.win[Cols-1] = column_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= 3'd0;
    end else if (accept_i) begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      for (int c = 0; c < Held - 1; c++) begin
        store_q[c] <= store_q[c+1];
      end
      store_q[Held-1] <= column_i;
    end
  end

endmodule

// ===== design/swa_terms.sv =====
module swa_terms
  import swa_pkg::*;
(
  input  window_t   win_i,
  input  sample_t   center_i,
  input  term_t     cap_i,
  output terms_t    terms_o
);

  function automatic term_t capped(sample_t a, sample_t b, sample_t ctr, term_t cap);
    logic signed [DiffW-1:0] d;
    logic [AbsW-1:0]         mag;
    d = DiffW'(a) + DiffW'(b) - (DiffW'(ctr) <<< 1);
    mag = d[DiffW-1] ? AbsW'(-d) : AbsW'(d);
    return (mag > AbsW'(cap)) ? cap : mag[CapW-1:0];
  endfunction

  always_comb begin
    for (int c = 0; c < Cols; c++) begin
      terms_o[c][0] = capped(win_i[c][0], win_i[Cols-1-c][4], center_i, cap_i);
      terms_o[c][1] = capped(win_i[c][1], win_i[Cols-1-c][3], center_i, cap_i);
      terms_o[c][2] = capped(win_i[c][2], win_i[Cols-1-c][2], center_i, cap_i);
    end
  end

endmodule

// ===== design/swa_sum.sv =====
module swa_sum
  import swa_pkg::*;
(
  input  terms_t     terms_i,
  output logic [7:0] activity_o
);

  logic [ColSumW-1:0] col_sum [Cols];
  logic [TotalW-1:0]  total;
  logic [TotalW-1:0]  rounded;
  logic [TotalW-8:0]  scaled;

  always_comb begin
    total = '0;
    for (int c = 0; c < Cols; c++) begin
      col_sum[c] = (ColSumW'(terms_i[c][0]) << 1) + (ColSumW'(terms_i[c][1]) << 3)
                 + (ColSumW'(terms_i[c][2]) << 2) + (ColSumW'(terms_i[c][2]) << 1);
      total = total + TotalW'(TotalW'(col_sum[c]) * TotalW'(ColWeight[c]));
    end
    rounded = total + RoundBias;
    scaled  = rounded[TotalW-1:7];
    activity_o = (scaled > (TotalW-7)'(OutMax)) ? OutMax : scaled[7:0];
  end

endmodule

// ===== design/symmetric_window_activity.sv =====
// Symmetric window activity.
// Input channel (in_valid_i / in_ready_o): one word per column of a 5x5
// window, five row samples plus the window's reference center and a
// line_start flag that restarts column filling for a new line.
// The first four columns of a line produce no output; each later column
// completes a window and yields one activity byte on the output channel
// (out_valid_o / out_ready_i).
// Capped terms are registered into stage one at the input accept edge;
// the weighted sum and saturation are registered into the output word,
// raising out_valid_o, when stage one advances (output empty or taken).
// Throughput: one column per cycle, sustained while the output is taken.
// cfg_we_i / cfg_wdata_i load cap_scale; write it only while idle.
// Reset clears the fill count, both pipeline valids and cap_scale to zero.
// When the receiver stalls, the output word holds and one more word can
// wait in stage one; in_ready_o drops only once both stages are full.
module symmetric_window_activity
  import swa_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] top_sample_i,
  input  logic signed [15:0] upper_sample_i,
  input  logic signed [15:0] middle_sample_i,
  input  logic signed [15:0] lower_sample_i,
  input  logic signed [15:0] bottom_sample_i,
  input  logic signed [15:0] center_value_i,
  input  logic               line_start_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         activity_o
);

  logic [7:0]  cap_scale_q;
  term_t       cap;
  logic        accept;
  logic        s1_advance;
  column_t     column;
  window_out_t win;
  terms_t      terms;
  logic        s1_valid_q;
  terms_t      s1_terms_q;
  logic        out_valid_q;
  logic [7:0]  activity_q;
  logic [7:0]  activity_d;

  assign cap = CapMask & (CapW'(cap_scale_q) << 3);

  assign s1_advance = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_advance;
  assign accept     = in_valid_i && in_ready_o;

  assign column = {bottom_sample_i, lower_sample_i, middle_sample_i,
                   upper_sample_i, top_sample_i};

  swa_window u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .column_i     (column),
    .line_start_i (line_start_i),
    .win_o        (win)
  );

  swa_terms u_terms (
    .win_i    (win.win),
    .center_i (center_value_i),
    .cap_i    (cap),
    .terms_o  (terms)
  );

  swa_sum u_sum (
    .terms_i    (s1_terms_q),
    .activity_o (activity_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_scale_q <= 8'd0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_scale_q <= cfg_wdata_i;
      end
      if (in_ready_o) begin
        s1_valid_q <= accept && win.fire;
      end
      if (s1_advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      s1_terms_q <= terms;
    end
    if (s1_advance) begin
      activity_q <= activity_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign activity_o  = activity_q;

endmodule

// ===== design/swa_checker.sv =====
module swa_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [7:0]         activity_o
);

  out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(activity_o))
    else $error("output word changed while stalled");

  ready_low_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled with room downstream");

  out_needs_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("output word without a matching input two cycles earlier");

  reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid right after reset");

endmodule

bind symmetric_window_activity swa_checker u_swa_checker (.*);

// ===== bench/symmetric_window_activity_tb.sv =====
`timescale 1ns / 100ps

module symmetric_window_activity_tb;
  import swa_pkg::*;

  typedef enum bit [1:0] {ROW_COL, ROW_CFG} row_kind_e;

  typedef struct packed {
    logic [15:0] top;
    logic [15:0] upper;
    logic [15:0] middle;
    logic [15:0] lower;
    logic [15:0] bottom;
    logic [15:0] center;
    logic        line_start;
  } column_word_t;

  typedef struct packed {
    row_kind_e    kind;
    logic [7:0]   scale;
    column_word_t word;
    int           typed_act;
  } dir_row_t;

  localparam int NoWord       = -1;
  localparam int Predicted    = -2;
  localparam int SettleCycles = 4;
  localparam int QuietLimit   = 5000;
  localparam int PhaseWords   = 60;
  localparam int Binomial [5] = '{1, 4, 6, 4, 1};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [7:0]  cfg_wdata_i = 8'h00;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [15:0] top_sample_i = '0;
  logic [15:0] upper_sample_i = '0;
  logic [15:0] middle_sample_i = '0;
  logic [15:0] lower_sample_i = '0;
  logic [15:0] bottom_sample_i = '0;
  logic [15:0] center_value_i = '0;
  logic        line_start_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  activity_o;

  // held columns of the current line, oldest first
  logic [15:0] held_col [4][5];
  int          fill_level = 0;
  logic [7:0]  cap_scale_q = 8'h00;

  logic [7:0]  pending_act [$];
  int          err_cnt = 0;
  int          words_sent = 0;
  int          acts_checked = 0;
  int          quiet_cycles = 0;
  int          sender_idle_pct = 0;
  int          recv_stall_pct = 0;

  dir_row_t dir_tab [28] = '{
    '{ROW_COL, 8'h00, '{16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h0000, 1'b1}, NoWord},
    '{ROW_COL, 8'h00, '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001, 16'h7fff, 1'b0}, NoWord},
    '{ROW_COL, 8'h00, '{16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'h8000, 1'b0}, NoWord},
    '{ROW_COL, 8'h00, '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0}, NoWord},
    '{ROW_COL, 8'h00, '{16'hffff, 16'h0001, 16'h8000, 16'h7fff, 16'h1234, 16'hedcb, 1'b0}, 0},
    '{ROW_COL, 8'h00, '{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 1'b0}, 0},
    '{ROW_CFG, 8'hff, '0, NoWord},
    '{ROW_COL, 8'h00, '{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 1'b1}, NoWord},
    '{ROW_COL, 8'h00, '{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 1'b0}, NoWord},
    '{ROW_COL, 8'h00, '{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 1'b0}, NoWord},
    '{ROW_COL, 8'h00, '{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 1'b0}, NoWord},
    '{ROW_COL, 8'h00, '{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 1'b0}, 255},
    '{ROW_COL, 8'h00, '{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 1'b0}, 0},
    '{ROW_COL, 8'h00, '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 1'b0},
      Predicted},
    '{ROW_CFG, 8'h01, '0, NoWord},
    '{ROW_COL, 8'h00, '{16'h0018, 16'h0008, 16'h0010, 16'h0014, 16'h000c, 16'h0010, 1'b1}, NoWord},
    '{ROW_COL, 8'h00, '{16'h0004, 16'h0020, 16'h0010, 16'h0000, 16'h001c, 16'h0012, 1'b0}, NoWord},
    '{ROW_COL, 8'h00, '{16'h0010, 16'h0011, 16'h000f, 16'h0010, 16'h0012, 16'h000e, 1'b1}, NoWord},
    '{ROW_COL, 8'h00, '{16'h0020, 16'h0000, 16'h0018, 16'h0008, 16'h0010, 16'h0010, 1'b0}, NoWord},
    '{ROW_COL, 8'h00, '{16'h0013, 16'h000d, 16'h0010, 16'h0015, 16'h000b, 16'h0011, 1'b0}, NoWord},
    '{ROW_COL, 8'h00, '{16'h0000, 16'h0030, 16'h0009, 16'h0017, 16'h0010, 16'h000f, 1'b0}, NoWord},
    '{ROW_COL, 8'h00, '{16'h001a, 16'h0006, 16'h0010, 16'h0010, 16'h0022, 16'h0010, 1'b0},
      Predicted},
    '{ROW_CFG, 8'h80, '0, NoWord},
    '{ROW_COL, 8'h00, '{16'h0100, 16'hff00, 16'h0200, 16'hfe00, 16'h0080, 16'h0000, 1'b1}, NoWord},
    '{ROW_COL, 8'h00, '{16'hff80, 16'h0180, 16'hfe80, 16'h0300, 16'hfd00, 16'h0040, 1'b0}, NoWord},
    '{ROW_COL, 8'h00, '{16'h0400, 16'hfc00, 16'h0000, 16'h0280, 16'hff40, 16'hffc0, 1'b0}, NoWord},
    '{ROW_COL, 8'h00, '{16'hfa00, 16'h0600, 16'h0120, 16'hfee0, 16'h0500, 16'h0020, 1'b0}, NoWord},
    '{ROW_COL, 8'h00, '{16'h0010, 16'hfff0, 16'h0700, 16'hf900, 16'h0000, 16'h0000, 1'b0},
      Predicted}
  };

  symmetric_window_activity uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .top_sample_i    (top_sample_i),
    .upper_sample_i  (upper_sample_i),
    .middle_sample_i (middle_sample_i),
    .lower_sample_i  (lower_sample_i),
    .bottom_sample_i (bottom_sample_i),
    .center_value_i  (center_value_i),
    .line_start_i    (line_start_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .activity_o      (activity_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int capped_diff(int a, int b, int twice_ctr, int cap);
    int d;
    d = a + b - twice_ctr;
    if (d < 0) d = -d;
    return (d > cap) ? cap : d;
  endfunction

  // updates the held columns and fill level; returns 1 when a window completes
  function automatic bit predict_activity(column_word_t w, output logic [7:0] act);
    int incoming [5];
    int win [5][5];
    int twice_ctr, cap, total, held;
    bit fires;
    incoming[0] = $signed(w.top);
    incoming[1] = $signed(w.upper);
    incoming[2] = $signed(w.middle);
    incoming[3] = $signed(w.lower);
    incoming[4] = $signed(w.bottom);
    twice_ctr = 2 * $signed(w.center);
    held = w.line_start ? 0 : fill_level;
    fires = (held >= 4);
    act = 8'h00;
    if (fires) begin
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 5; r++) win[r][c] = $signed(held_col[c][r]);
      for (int r = 0; r < 5; r++) win[r][4] = incoming[r];
      cap = int'({cap_scale_q, 3'b000});
      total = 0;
      for (int c = 0; c < 5; c++)
        total += Binomial[c] * (2 * capped_diff(win[0][c], win[4][4-c], twice_ctr, cap)
                              + 8 * capped_diff(win[1][c], win[3][4-c], twice_ctr, cap)
                              + 6 * capped_diff(win[2][c], win[2][4-c], twice_ctr, cap));
      total = (total + 64) >>> 7;
      if (total > 255) total = 255;
      act = total[7:0];
    end
    for (int c = 0; c < 3; c++)
      for (int r = 0; r < 5; r++) held_col[c][r] = held_col[c+1][r];
    for (int r = 0; r < 5; r++) held_col[3][r] = incoming[r][15:0];
    fill_level = (held < 4) ? held + 1 : 4;
    return fires;
  endfunction

  function automatic logic [15:0] near_value(logic [15:0] base);
    if ($urandom_range(7) == 0) return 16'($urandom);
    return base + 16'($urandom_range(127)) - 16'd64;
  endfunction

  task automatic send_column(column_word_t w, int typed_act);
    logic [7:0] act;
    bit fires;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    top_sample_i    <= w.top;
    upper_sample_i  <= w.upper;
    middle_sample_i <= w.middle;
    lower_sample_i  <= w.lower;
    bottom_sample_i <= w.bottom;
    center_value_i  <= w.center;
    line_start_i    <= w.line_start;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    words_sent++;
    fires = predict_activity(w, act);
    if (typed_act == Predicted) begin
      if (fires) pending_act.push_back(act);
    end else if (typed_act != NoWord) begin
      pending_act.push_back(typed_act[7:0]);
    end
  endtask

  // stops the stream, waits until the pipe is empty, then loads cap_scale
  task automatic set_scale(logic [7:0] v);
    in_valid_i <= 1'b0;
    while (pending_act.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cap_scale_q = v;
  endtask

  task automatic send_line(int len);
    logic [15:0] base;
    column_word_t w;
    base = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 16'h7fff : 16'h8000)
                                    : 16'($urandom);
    for (int k = 0; k < len; k++) begin
      w.top        = near_value(base);
      w.upper      = near_value(base);
      w.middle     = near_value(base);
      w.lower      = near_value(base);
      w.bottom     = near_value(base);
      w.center     = base + 16'($urandom_range(15)) - 16'd8;
      w.line_start = (k == 0) ? ($urandom_range(9) != 0) : ($urandom_range(39) == 0);
      send_column(w, Predicted);
    end
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    logic [7:0] want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_act.size() == 0) begin
        err_cnt++;
        $display("%0t: activity word %0d with none expected", $time, activity_o);
      end else begin
        want = pending_act.pop_front();
        acts_checked++;
        if (activity_o !== want) begin
          err_cnt++;
          $display("%0t: activity mismatch, expected %0d, got %0d", $time, want, activity_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int left, len;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int k = 0; k < 28; k++) begin
      if (dir_tab[k].kind == ROW_CFG) set_scale(dir_tab[k].scale);
      else send_column(dir_tab[k].word, dir_tab[k].typed_act);
    end

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin
          sender_idle_pct = 0;
          recv_stall_pct  = 0;
        end
        1: begin
          sender_idle_pct = 73;
          recv_stall_pct  = 0;
        end
        2: begin
          sender_idle_pct = 0;
          recv_stall_pct  = 73;
        end
        default: begin
          sender_idle_pct = 36;
          recv_stall_pct  = 36;
        end
      endcase
      case (ph)
        0: set_scale(8'hff);
        1: set_scale(8'h00);
        2: set_scale(8'h01);
        3: set_scale(8'h80);
        default: set_scale(8'($urandom_range(2, 40)));
      endcase
      left = PhaseWords;
      while (left > 0) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 16);
        if (len > left) len = left;
        send_line(len);
        left -= len;
      end
    end

    in_valid_i <= 1'b0;
    while (pending_act.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Streamed %0d columns (directed table, then 8 random phases over cap scales",
             words_sent);
    $display("and idle mixes); %0d activity words checked, %0d mismatches",
             acts_checked, err_cnt);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
